// ----- rtl/rsa_pkg.sv -----
// Shared types and constants of the reference-counted slot allocator.
package rsa_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned REQ_W    = 10;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_REF   = 2'd1,
    CMD_DEREF = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_USED  = 2'd2,
    ST_COUNT_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0] slot_index;
    logic [CNT_W-1:0] ref_count;
    status_e          status;
  } result_t;

endpackage

// ----- rtl/rsa_if.sv -----
// Command and response channel interfaces of the slot allocator.
interface rsa_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [rsa_pkg::CMD_W-1:0]  command;
  logic [rsa_pkg::REQ_W-1:0]  slot_request;

  modport source (output valid, command, slot_request, input ready);
  modport sink   (input valid, command, slot_request, output ready);
endinterface

interface rsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rsa_pkg::REQ_W-1:0]     slot_index;
  logic [rsa_pkg::CNT_W-1:0]     ref_count;
  logic [rsa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, slot_index, ref_count, status, input ready);
  modport sink   (input valid, slot_index, ref_count, status, output ready);
endinterface

// ----- rtl/refcounted_slot_allocator_unit.sv -----
// Top level of the reference-counted slot allocator.
//
// Commands enter on req_i: allocate a slot, add a reference or drop a
// reference. Every command gives exactly one response on rsp_o carrying the
// slot, its count after the operation and a status code.
// One command is worked on at a time. Rejected and directly decided commands
// (unknown command, slot not in use, pool full, allocation without a scan)
// go from acceptance through the S_DONE state to the response register; add
// and drop reference first pass through S_RD and S_MOD, the count memory's
// read-modify-write (address, registered read, write back). An allocation
// that reuses a slot scans the counts one per cycle upwards from the slot
// above the one handed out, bounded by the highest free hint.
// The response register is separate from the sequencer, so the next command
// is accepted and worked on while a response waits; a stalled receiver
// blocks new commands only once a second response is ready.
// Reset clears the hints and the in-use count at once; the count memory is
// not cleared, since every slot is written when it is handed out.
module refcounted_slot_allocator_unit #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsa_cmd_if.sink     req_i,
  rsa_rsp_if.source   rsp_o
);
  import rsa_pkg::*;

  localparam int unsigned IW = $clog2(SLOT_COUNT);

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic                  out_valid_q;
  result_t               out_q;

  rsa_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (req_i.valid),
    .cmd_ready_o    (req_i.ready),
    .command_i      (req_i.command),
    .slot_request_i (req_i.slot_request),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  rsa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Response register: load when empty or being drained
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '{slot_index: '0, ref_count: '0, status: ST_OK};
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.slot_index = out_q.slot_index;
  assign rsp_o.ref_count  = out_q.ref_count;
  assign rsp_o.status     = out_q.status;

endmodule

// ----- rtl/rsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rsa_ctrl.sv -----
// Sequencer of the slot allocator: hints, count read-modify-write and free-slot scan.
module rsa_ctrl #(
  parameter int unsigned SLOT_COUNT = 1024,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  logic [rsa_pkg::CMD_W-1:0]   command_i,
  input  logic [rsa_pkg::REQ_W-1:0]   slot_request_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output rsa_pkg::result_t            res_o,
  output logic                        ram_we_o,
  output logic [$clog2(SLOT_COUNT)-1:0] ram_waddr_o,
  output logic [COUNT_BITS-1:0]       ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(SLOT_COUNT)-1:0] ram_raddr_o,
  input  logic [COUNT_BITS-1:0]       ram_rdata_i
);
  import rsa_pkg::*;

  localparam int unsigned IW   = $clog2(SLOT_COUNT);
  localparam int unsigned UW   = IW + 1;
  localparam int unsigned CMPW = (UW > REQ_W) ? UW : REQ_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_SCAN,
    S_DONE
  } state_e;

  state_e           state_q;
  cmd_e             cmd_q;
  logic [IW-1:0]    idx_q;
  logic [UW-1:0]    used_q;
  logic [UW-1:0]    lf_q;
  logic [UW-1:0]    hf_q;
  logic [UW-1:0]    ka_q;
  logic [IW-1:0]    kc_q;
  logic             chk_q;
  result_t          res_q;

  cmd_e             cmd_in;
  logic             accept;
  logic             in_range;
  logic             reuse;
  logic             full;
  logic             scan_hit;
  logic             scan_issue;

  assign cmd_in     = cmd_e'(command_i);
  assign accept     = cmd_valid_i && (state_q == S_IDLE);
  assign in_range   = CMPW'(slot_request_i) < CMPW'(used_q);
  assign reuse      = lf_q < used_q;
  assign full       = used_q == UW'(SLOT_COUNT);
  assign scan_hit   = chk_q && (ram_rdata_i == '0);
  assign scan_issue = (ka_q <= hf_q) && (ka_q < used_q);

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = state_q == S_DONE;
  assign res_o       = res_q;

  // Memory port control
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        // clear the count of the slot handed out
        if (accept && cmd_in == CMD_ALLOC) begin
          if (reuse) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = lf_q[IW-1:0];
          end else if (!full) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = used_q[IW-1:0];
          end
        end
      end
      S_RD: begin
        ram_re_o = 1'b1;
      end
      S_MOD: begin
        if (cmd_q == CMD_REF) begin
          ram_we_o    = ram_rdata_i != CNT_MAX;
          ram_wdata_o = ram_rdata_i + CNT_ONE;
        end else begin
          ram_we_o    = ram_rdata_i != '0;
          ram_wdata_o = ram_rdata_i - CNT_ONE;
        end
      end
      S_SCAN: begin
        ram_re_o    = scan_issue && !scan_hit;
        ram_raddr_o = ka_q[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_ALLOC;
      idx_q   <= '0;
      used_q  <= '0;
      lf_q    <= '0;
      hf_q    <= '0;
      ka_q    <= '0;
      kc_q    <= '0;
      chk_q   <= 1'b0;
      res_q   <= '{slot_index: '0, ref_count: '0, status: ST_OK};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_in;
            idx_q <= IW'(slot_request_i);
            case (cmd_in)
              CMD_ALLOC: begin
                if (reuse) begin
                  res_q  <= '{slot_index: REQ_W'(lf_q), ref_count: '0, status: ST_OK};
                  if (lf_q >= hf_q) begin
                    lf_q    <= used_q;
                    hf_q    <= '0;
                    state_q <= S_DONE;
                  end else begin
                    ka_q    <= lf_q + UW'(1);
                    chk_q   <= 1'b0;
                    state_q <= S_SCAN;
                  end
                end else if (full) begin
                  res_q   <= '{slot_index: '0, ref_count: '0, status: ST_FULL};
                  state_q <= S_DONE;
                end else begin
                  used_q  <= used_q + UW'(1);
                  lf_q    <= used_q + UW'(1);
                  hf_q    <= '0;
                  res_q   <= '{slot_index: REQ_W'(used_q), ref_count: '0, status: ST_OK};
                  state_q <= S_DONE;
                end
              end
              CMD_REF, CMD_DEREF: begin
                if (in_range) begin
                  state_q <= S_RD;
                end else begin
                  res_q   <= '{slot_index: slot_request_i, ref_count: '0,
                               status: ST_NOT_USED};
                  state_q <= S_DONE;
                end
              end
              default: begin
                res_q   <= '{slot_index: slot_request_i, ref_count: '0,
                             status: ST_NOT_USED};
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          res_q.slot_index <= REQ_W'(idx_q);
          if (cmd_q == CMD_REF) begin
            if (ram_rdata_i == CNT_MAX) begin
              res_q.ref_count <= CNT_W'(ram_rdata_i);
              res_q.status    <= ST_COUNT_ERR;
            end else begin
              res_q.ref_count <= CNT_W'(ram_rdata_i + CNT_ONE);
              res_q.status    <= ST_OK;
            end
          end else begin
            if (ram_rdata_i == '0) begin
              res_q.ref_count <= '0;
              res_q.status    <= ST_COUNT_ERR;
            end else begin
              res_q.ref_count <= CNT_W'(ram_rdata_i - CNT_ONE);
              res_q.status    <= ST_OK;
              // slot freed: widen the free hints
              if (ram_rdata_i == CNT_ONE) begin
                if (UW'(idx_q) < lf_q) begin
                  lf_q <= UW'(idx_q);
                end
                if (UW'(idx_q) > hf_q) begin
                  hf_q <= UW'(idx_q);
                end
              end
            end
          end
          state_q <= S_DONE;
        end
        S_SCAN: begin
          // one read issued per cycle, checked when its data returns
          if (scan_hit) begin
            lf_q    <= UW'(kc_q);
            state_q <= S_DONE;
          end else if (scan_issue) begin
            kc_q  <= ka_q[IW-1:0];
            chk_q <= 1'b1;
            ka_q  <= ka_q + UW'(1);
          end else begin
            lf_q    <= used_q;
            hf_q    <= '0;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
